[design/ptd_pkg.sv]
// Shared types and constants of the priority task dispatcher.
// Request and result payloads, controller commands and datapath status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

	localparam int IDLE_BITS = 8;

	localparam logic [1:0] KIND_SCHEDULED = 2'd0;
	localparam logic [1:0] KIND_FULL      = 2'd1;
	localparam logic [1:0] KIND_DISPATCH  = 2'd2;
	localparam logic [1:0] KIND_DONE      = 2'd3;

	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	typedef struct packed {
		logic        op;
		logic [15:0] intensity;
		logic [7:0]  idle_cores;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] task_number;
		logic [2:0]  core_index;
		logic [15:0] task_intensity;
		logic        last;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic load;        // capture request, rewind counters
		logic slot_step;   // advance slot counter
		logic scan_rd;     // read slot tables at slot counter
		logic find_clr;    // start a new best-task search
		logic core_next;   // advance core counter
		logic sched_write; // store new task, emit scheduled
		logic emit_full;   // emit queue full
		logic disp_commit; // free best task, emit dispatch
		logic emit_done;   // emit tick done
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic slot_free;
		logic slot_last;
		logic core_end;
		logic core_idle;
		logic found;
	} sts_t;

endpackage

`default_nettype wire

[design/ptd_ctrl.sv]
// Sequencing state machine of the priority task dispatcher.
// Depends on ptd_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module ptd_ctrl import ptd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic op,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      busy
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCHED = 3'd1;
	localparam logic [2:0] ST_TCORE = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_DISP  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (op == OP_TICK) ? ST_TCORE : ST_SCHED;
				end
			end
			ST_SCHED: begin
				priority if (sts.slot_free) begin
					cmd.sched_write = 1'b1;
					state_d         = ST_IDLE;
				end else if (sts.slot_last) begin
					cmd.emit_full = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.slot_step = 1'b1;
				end
			end
			ST_TCORE: begin
				priority if (sts.core_end) begin
					cmd.emit_done = 1'b1;
					state_d       = ST_IDLE;
				end else if (!sts.core_idle) begin
					cmd.core_next = 1'b1;
				end else begin
					cmd.find_clr = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd   = 1'b1;
				cmd.slot_step = 1'b1;
				if (sts.slot_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last slot's compare lands this cycle
				state_d = ST_DISP;
			end
			ST_DISP: begin
				cmd.disp_commit = sts.found;
				cmd.core_next   = 1'b1;
				state_d         = ST_TCORE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[design/ptd_dp.sv]
// Datapath of the priority task dispatcher: slot tables, counters,
// best-task search pipeline and result register. Depends on ptd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptd_dp import ptd_pkg::*; #(
	parameter int TASK_SLOTS = 16,
	parameter int CORE_COUNT = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire req_t       request,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire cmd_t       cmd,
	output sts_t            sts,
	output rsp_t            result,
	output logic            strobe
);

	localparam int SIDX_W   = $clog2(TASK_SLOTS);
	localparam int CORE_LIM = (CORE_COUNT < IDLE_BITS) ? CORE_COUNT : IDLE_BITS;
	localparam logic [SIDX_W-1:0] SLOT_LAST = SIDX_W'(TASK_SLOTS - 1);
	localparam logic [3:0]        LIMIT_MAX = 4'(CORE_LIM);

	// tables
	logic [15:0] int_mem [TASK_SLOTS];
	logic [15:0] num_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] valid_q;

	req_t              req_q;
	logic [3:0]        online_q;
	logic [15:0]       next_num_q;
	logic [SIDX_W-1:0] slot_q;
	logic [3:0]        core_q;

	// search pipeline
	logic              rd_s1;
	logic [SIDX_W-1:0] slot_s1;
	logic [15:0]       rd_int_s1;
	logic [15:0]       rd_num_s1;
	logic              found_q;
	logic [SIDX_W-1:0] best_slot_q;
	logic [15:0]       best_int_q;
	logic [15:0]       best_num_q;

	rsp_t        rsp_q;
	logic        stb_q;
	logic [3:0]  limit;
	logic [15:0] num_inc;
	logic        better;

	assign limit   = (online_q > LIMIT_MAX) ? LIMIT_MAX : online_q;
	assign num_inc = next_num_q + 16'd1;
	assign better  = rd_s1 && valid_q[slot_s1] && (!found_q || (rd_int_s1 > best_int_q));

	always_comb begin
		sts.slot_free = !valid_q[slot_q];
		sts.slot_last = (slot_q == SLOT_LAST);
		sts.core_end  = (core_q >= limit);
		sts.core_idle = req_q.idle_cores[core_q[2:0]];
		sts.found     = found_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_q   <= 4'd1;
			valid_q    <= '0;
			next_num_q <= '0;
			slot_q     <= '0;
			core_q     <= '0;
			rd_s1      <= 1'b0;
			found_q    <= 1'b0;
			stb_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				online_q <= cfg_wdata;
			end
			rd_s1 <= cmd.scan_rd;
			stb_q <= cmd.sched_write | cmd.emit_full | cmd.disp_commit | cmd.emit_done;
			priority if (cmd.load || cmd.find_clr) begin
				slot_q <= '0;
			end else if (cmd.slot_step) begin
				slot_q <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end else begin
				slot_q <= slot_q;
			end
			priority if (cmd.load) begin
				core_q <= '0;
			end else if (cmd.core_next) begin
				core_q <= core_q + 4'd1;
			end else begin
				core_q <= core_q;
			end
			priority if (cmd.find_clr) begin
				found_q <= 1'b0;
			end else if (better) begin
				found_q <= 1'b1;
			end else begin
				found_q <= found_q;
			end
			if (cmd.sched_write) begin
				valid_q[slot_q] <= 1'b1;
				next_num_q      <= num_inc;
			end
			if (cmd.disp_commit) begin
				valid_q[best_slot_q] <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		if (cmd.sched_write) begin
			int_mem[slot_q] <= req_q.intensity;
			num_mem[slot_q] <= num_inc;
		end
		if (cmd.scan_rd) begin
			rd_int_s1 <= int_mem[slot_q];
			rd_num_s1 <= num_mem[slot_q];
			slot_s1   <= slot_q;
		end
		if (better) begin
			best_slot_q <= slot_s1;
			best_int_q  <= rd_int_s1;
			best_num_q  <= rd_num_s1;
		end
		priority if (cmd.sched_write) begin
			rsp_q <= '{kind: KIND_SCHEDULED, task_number: num_inc, core_index: 3'd0,
				task_intensity: 16'd0, last: 1'b1};
		end else if (cmd.emit_full) begin
			rsp_q <= '{kind: KIND_FULL, task_number: 16'd0, core_index: 3'd0,
				task_intensity: 16'd0, last: 1'b1};
		end else if (cmd.disp_commit) begin
			rsp_q <= '{kind: KIND_DISPATCH, task_number: best_num_q,
				core_index: core_q[2:0], task_intensity: best_int_q, last: 1'b0};
		end else if (cmd.emit_done) begin
			rsp_q <= '{kind: KIND_DONE, task_number: 16'd0, core_index: 3'd0,
				task_intensity: 16'd0, last: 1'b1};
		end else begin
			rsp_q <= rsp_q;
		end
	end

	assign result = rsp_q;
	assign strobe = stb_q;

endmodule

`default_nettype wire

[design/priority_task_dispatcher.sv]
// Priority task dispatcher: schedule walks the slots serially for the lowest free one;
// tick steps through the online cores and scans the whole table for each idle one.
// Each result leaves the output register in the cycle after it is formed; no stall.
// One request at a time: busy stays high until the request's last result is formed.
// Reset (arst_n low, async): tables empty, ID counter 0, cores_online 1.
// Depends on ptd_pkg, ptd_ctrl and ptd_dp.
`timescale 1ns / 1ps
`default_nettype none

module priority_task_dispatcher import ptd_pkg::*; #(
	parameter int TASK_SLOTS = 16,
	parameter int CORE_COUNT = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// request channel
	input  wire logic       start,
	input  wire req_t       request,
	output logic            busy,
	// result channel, one cycle per result
	output logic            strobe,
	output rsp_t            result,
	// cores_online register
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata
);

	// Controller walks the request: schedule scans the valid bits for the
	// lowest free slot; a tick steps through the cores and, for each idle
	// one, streams the whole table through a registered compare.
	cmd_t cmd;
	sts_t sts;

	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (request.op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Datapath owns the tables, counters and the result register.
	ptd_dp #(
		.TASK_SLOTS (TASK_SLOTS),
		.CORE_COUNT (CORE_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result),
		.strobe    (strobe)
	);

	// at most one result formed per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sched_write, cmd.emit_full, cmd.disp_commit, cmd.emit_done}))
		else $error("more than one result formed in a cycle");

	// results only come out of a request in progress
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("result without a request in progress");

	// the closing result frees the block
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> !busy)
		else $error("still busy after the last result");

	// only dispatches are followed by more results
	a_notlast_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> (result.kind == KIND_DISPATCH))
		else $error("non-final result that is not a dispatch");

endmodule

`default_nettype wire

[tb/ptd_tb_pkg.sv]
// Task table tracker for the priority task dispatcher bench: mirrors the slot table,
// works out the results each accepted request should give and checks them in order.
// Depends on ptd_pkg.
`timescale 1ns / 1ps

package ptd_tb_pkg;
	import ptd_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int CORE_LIMIT  = 8;

	class dispatch_tracker;
		bit          slot_busy[TABLE_DEPTH];
		logic [15:0] slot_id[TABLE_DEPTH];
		logic [15:0] slot_weight[TABLE_DEPTH];
		logic [15:0] last_id;
		logic [3:0]  online;
		rsp_t        due_results[$];
		int          mismatches;

		function new();
			foreach (slot_busy[s]) begin
				slot_busy[s]   = 1'b0;
				slot_id[s]     = '0;
				slot_weight[s] = '0;
			end
			last_id    = '0;
			online     = 4'd1;
			mismatches = 0;
		endfunction

		function void set_online(input logic [3:0] v);
			online = v;
		endfunction

		function logic [15:0] issued_id();
			return last_id;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function rsp_t make_result(input logic [1:0] k, input logic [15:0] id,
		                           input logic [2:0] core, input logic [15:0] w,
		                           input logic fin);
			rsp_t e;
			e.kind           = k;
			e.task_number    = id;
			e.core_index     = core;
			e.task_intensity = w;
			e.last           = fin;
			return e;
		endfunction

		// expected results of one accepted request; updates the table
		function void accept_request(input req_t r);
			int free_slot;
			int cores;
			int best;
			if (r.op == OP_SCHEDULE) begin
				free_slot = -1;
				for (int s = 0; s < TABLE_DEPTH; s++)
					if (!slot_busy[s] && free_slot < 0)
						free_slot = s;
				if (free_slot >= 0) begin
					last_id                = last_id + 16'd1;
					slot_busy[free_slot]   = 1'b1;
					slot_id[free_slot]     = last_id;
					slot_weight[free_slot] = r.intensity;
					due_results.push_back(make_result(KIND_SCHEDULED, last_id, 3'd0,
					                                  16'd0, 1'b1));
				end else begin
					due_results.push_back(make_result(KIND_FULL, 16'd0, 3'd0, 16'd0, 1'b1));
				end
			end else begin
				cores = (online > CORE_LIMIT) ? CORE_LIMIT : int'(online);
				if (cores > IDLE_BITS)
					cores = IDLE_BITS;
				for (int c = 0; c < cores; c++) begin
					if (r.idle_cores[c]) begin
						best = -1;
						for (int s = 0; s < TABLE_DEPTH; s++)
							if (slot_busy[s] && (best < 0 || slot_weight[s] > slot_weight[best]))
								best = s;
						if (best >= 0) begin
							due_results.push_back(make_result(KIND_DISPATCH, slot_id[best],
							                                  3'(c), slot_weight[best], 1'b0));
							slot_busy[best] = 1'b0;
						end
					end
				end
				due_results.push_back(make_result(KIND_DONE, 16'd0, 3'd0, 16'd0, 1'b1));
			end
		endfunction

		function void check_result(input rsp_t got);
			rsp_t want;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d id %0d core %0d weight %0d last %0d",
					         got.kind, got.task_number, got.core_index, got.task_intensity,
					         got.last);
				return;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind || got.task_number !== want.task_number ||
			    got.core_index !== want.core_index ||
			    got.task_intensity !== want.task_intensity || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result differs: expected kind %0d id %0d core %0d weight %0d last %0d, got kind %0d id %0d core %0d weight %0d last %0d",
					         want.kind, want.task_number, want.core_index, want.task_intensity,
					         want.last, got.kind, got.task_number, got.core_index,
					         got.task_intensity, got.last);
			end
		endfunction
	endclass

endpackage

[tb/testbench.sv]
// Self-checking bench for priority_task_dispatcher: directed requests, then random
// phases under several core counts; results checked in order.
// Depends on ptd_pkg, ptd_tb_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module testbench;
	import ptd_pkg::*;
	import ptd_tb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	req_t       request;
	logic       busy;
	logic       strobe;
	rsp_t       result;
	logic       cfg_we;
	logic [3:0] cfg_wdata;

	dispatch_tracker tracker = new();

	priority_task_dispatcher #(
		.TASK_SLOTS (16),
		.CORE_COUNT (8)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.strobe    (strobe),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// results cannot be held off: take each strobed one at the edge closing its cycle
	always @(posedge clk) begin
		if (arst_n === 1'b1 && strobe === 1'b1)
			tracker.check_result(result);
	end

	// ---- request builders; fields the operation ignores are still randomised ----
	function automatic req_t schedule_req(input logic [15:0] w);
		req_t r;
		r.op         = OP_SCHEDULE;
		r.intensity  = w;
		r.idle_cores = 8'($urandom);
		return r;
	endfunction

	function automatic req_t tick_req(input logic [7:0] idle);
		req_t r;
		r.op         = OP_TICK;
		r.intensity  = 16'($urandom);
		r.idle_cores = idle;
		return r;
	endfunction

	// extremes, a handful of small values to force ties, or anything
	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: return 16'($urandom_range(0, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_idle();
		case ($urandom_range(0, 5))
			0: return 8'hFF;
			1: return 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// ---- drivers ----
	// A request is taken at the edge where start is high and busy is low. Start stays
	// high between back-to-back requests and drops only for a gap or to drain results.
	task automatic send_request(input req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.accept_request(r);
	endtask

	// hold the sender off until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_online(input logic [3:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.set_online(v);
	endtask

	initial begin
		logic [3:0] online;
		int         sched_pct;
		int         gap;
		req_t       r;

		arst_n    <= 1'b0;
		start     <= 1'b0;
		request   <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed part, one online core after reset ----
		send_request(tick_req(8'hFF), 0);       // idle core, empty table: tick done only
		send_request(schedule_req(16'h0000), 0);
		send_request(schedule_req(16'hFFFF), 0);
		send_request(tick_req(8'h00), 0);       // nobody idle
		send_request(tick_req(8'h01), 0);       // core 0 takes the 0xFFFF task
		send_request(tick_req(8'hFE), 0);       // only offline cores idle
		drain_results();
		write_online(4'd8);
		// fill the table with repeated weights so the tie rule matters
		for (int i = 0; i < 15; i++)
			send_request(schedule_req((i % 3 == 0) ? 16'hAAAA :
			                          (i % 3 == 1) ? 16'h5555 : 16'hFFFF), 0);
		send_request(schedule_req(16'h1234), 0); // table full
		send_request(tick_req(8'hFF), 0);        // all eight cores served
		drain_results();
		write_online(4'd0);
		send_request(tick_req(8'hFF), 0);        // no core online
		drain_results();
		write_online(4'd15);                     // saturates at eight
		send_request(tick_req(8'hAA), 0);

		// ---- random phases ----
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			case (ph)
				0: online = 4'd15;
				1: online = 4'd0;
				2: online = 4'd8;
				3: online = 4'd1;
				default: online = 4'($urandom_range(0, 15));
			endcase
			write_online(online);
			sched_pct = $urandom_range(35, 75);
			for (int n = 0; n < 43; n++) begin
				// idle bursts, none in the final phase
				gap = (ph < 7 && $urandom_range(0, 99) < 30) ? $urandom_range(1, 9) : 0;
				if ($urandom_range(0, 99) < sched_pct)
					r = schedule_req(pick_weight());
				else
					r = tick_req(pick_idle());
				send_request(r, gap);
			end
		end

		start <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("priority_task_dispatcher: match");
		else
			$display("priority_task_dispatcher: mismatch");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#(2_000_000);
		$display("priority_task_dispatcher: mismatch");
		$finish;
	end

endmodule
